FILE: rtl/clsr_pkg.sv
// Shared constants, codes and types for the combined LCG shuffle generator.
package clsr_pkg;

  // Shuffle table geometry and seeding length
  localparam int TABLE_ENTRIES = 32;
  localparam int WARMUP_STEPS  = 8;
  localparam int TOTAL_STEPS   = TABLE_ENTRIES + WARMUP_STEPS;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int STEP_W        = $clog2(TOTAL_STEPS + 1);

  // Value widths
  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int FOLD_W = 8;

  // Generator constants
  localparam logic [VAL_W-1:0] MOD_ONE      = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD_TWO      = 31'd2147483399;
  localparam logic [VAL_W-1:0] MOD_ONE_LESS = 31'd2147483562;
  localparam logic [VAL_W-1:0] SEED_LIMIT   = 31'd2147383562;
  localparam logic [MUL_W-1:0] MUL_ONE      = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_TWO      = 16'd40692;

  // 2^31 mod m for each modulus, used to fold the high product bits back in
  localparam logic [FOLD_W-1:0] FOLD_ONE = 8'(64'h8000_0000 - 64'(MOD_ONE));
  localparam logic [FOLD_W-1:0] FOLD_TWO = 8'(64'h8000_0000 - 64'(MOD_TWO));

  // Bucket width that maps the previous output onto a table index
  localparam longint DIVISOR = 64'd2147483562 / TABLE_ENTRIES + 1;

  // Operation codes
  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_SEED = 1'b1
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_STORE,
    ST_COMBINE
  } state_t;

endpackage

FILE: rtl/combined_lcg_shuffle_rng_top.sv
// Top level of the combined two-LCG random generator with shuffle table.
//
// Each transfer on the input carries an operation: draw or reseed. A draw
// returns one 31-bit number in 1..2147483562. It steps the first and then
// the second generator; the result register loads in the combine state,
// later if the previous result is still waiting there. A reseed returns
// nothing and runs TABLE_ENTRIES + WARMUP_STEPS steps of the first
// generator. Both use the single multiply-and-reduce unit, which takes each
// generator step through the MUL, FOLD and STORE states and serves both
// generators in turn. The block takes one item at a time; a finished draw
// sits in the output register while the next item is accepted. Reseed before
// the first draw: the shuffle table holds nothing meaningful until then.
module combined_lcg_shuffle_rng_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [31:0]                in_seed_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [clsr_pkg::VAL_W-1:0] out_random_value
);
  import clsr_pkg::*;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic               two_r, two_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [VAL_W-1:0]   g1_r, g1_nxt;
  logic [VAL_W-1:0]   g2_r, g2_nxt;
  logic [VAL_W-1:0]   last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_data_r, out_data_nxt;

  logic [VAL_W-1:0]   seed_masked;
  logic [VAL_W-1:0]   seed_clean;
  logic [IDX_W-1:0]   draw_idx;
  logic [VAL_W-1:0]   mm_x;
  logic [VAL_W-1:0]   mm_result;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [VAL_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [VAL_W-1:0]   ram_rd_data;
  logic               entry_gt;
  logic [VAL_W:0]     y_sum;
  logic [VAL_W-1:0]   draw_y;

  // shared multiply-reduce unit
  assign mm_x = two_r ? g2_r : g1_r;

  clsr_mulmod u_mulmod (
    .clk     (clk),
    .use_two (two_r),
    .x       (mm_x),
    .result  (mm_result)
  );

  // shuffle table
  clsr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (draw_idx),
    .rd_data (ram_rd_data)
  );

  // clean up the seed: zero or out-of-range seeds become one
  always_comb begin
    seed_masked = in_seed_value[VAL_W-1:0];
    if (seed_masked == '0 || seed_masked > SEED_LIMIT) begin
      seed_clean = VAL_W'(1);
    end else begin
      seed_clean = seed_masked;
    end
  end

  // table index: count the bucket boundaries at or below the last output
  always_comb begin
    draw_idx = '0;
    for (int k = 1; k < TABLE_ENTRIES; k++) begin
      if ({1'b0, last_r} >= 32'(k * DIVISOR)) begin
        draw_idx = IDX_W'(k);
      end
    end
  end

  // entry minus second generator, wrapped into 1..m1-1
  always_comb begin
    entry_gt = ram_rd_data > g2_r;
    y_sum    = {1'b0, ram_rd_data} - {1'b0, g2_r}
             + (entry_gt ? '0 : {1'b0, MOD_ONE_LESS});
    draw_y   = y_sum[VAL_W-1:0];
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    two_nxt       = two_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    g1_nxt        = g1_r;
    g2_nxt        = g2_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = g1_r;
    ram_rd_en     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_operation);
          two_nxt   = 1'b0;
          state_nxt = ST_MUL;
          if (op_t'(in_operation) == OP_SEED) begin
            g1_nxt   = seed_clean;
            g2_nxt   = seed_clean;
            step_nxt = STEP_W'(TOTAL_STEPS - 1);
          end else begin
            // fetch the entry picked by the previous output
            ram_rd_en = 1'b1;
            idx_nxt   = draw_idx;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        if (op_r == OP_SEED) begin
          // advance the first generator, fill the table on the last steps
          g1_nxt = mm_result;
          if (step_r < STEP_W'(TABLE_ENTRIES)) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = step_r[IDX_W-1:0];
            ram_wr_data = mm_result;
          end
          if (step_r == '0) begin
            last_nxt  = mm_result;
            state_nxt = ST_IDLE;
          end else begin
            step_nxt  = step_r - STEP_W'(1);
            state_nxt = ST_MUL;
          end
        end else if (!two_r) begin
          g1_nxt    = mm_result;
          two_nxt   = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          g2_nxt    = mm_result;
          state_nxt = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        // hold until the output register is free, then refill the entry
        if (!out_valid_r || out_ready) begin
          ram_wr_en     = 1'b1;
          ram_wr_addr   = idx_r;
          ram_wr_data   = g1_r;
          last_nxt      = draw_y;
          out_valid_nxt = 1'b1;
          out_data_nxt  = draw_y;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and generator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      g1_r        <= VAL_W'(1);
      g2_r        <= VAL_W'(1);
      op_r        <= OP_DRAW;
      two_r       <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      g1_r        <= g1_nxt;
      g2_r        <= g2_nxt;
      op_r        <= op_nxt;
      two_r       <= two_nxt;
      step_r      <= step_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_random_value = out_data_r;

endmodule

FILE: rtl/clsr_ram.sv
// Generic simple dual-port RAM with registered read.
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

FILE: rtl/clsr_mulmod.sv
// Shared multiply and constant-modulus reduction unit, two register stages.
module clsr_mulmod (
  input  logic                       clk,
  input  logic                       use_two,
  input  logic [clsr_pkg::VAL_W-1:0] x,
  output logic [clsr_pkg::VAL_W-1:0] result
);
  import clsr_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic               two_s1_r;
  logic [VAL_W:0]     fold_r;
  logic [VAL_W:0]     fold_nxt;
  logic               two_s2_r;
  logic [MUL_W-1:0]   mul_const;
  logic [FOLD_W-1:0]  fold_const;
  logic [VAL_W:0]     mod_ext;

  // multiply by the generator's multiplier
  always_comb begin
    mul_const = use_two ? MUL_TWO : MUL_ONE;
    prod_nxt  = {{MUL_W{1'b0}}, x} * {{VAL_W{1'b0}}, mul_const};
  end

  // fold bits above 2^31 back in as hi * (2^31 mod m); sum stays below 2m
  always_comb begin
    fold_const = two_s1_r ? FOLD_TWO : FOLD_ONE;
    fold_nxt   = {{(VAL_W + 1 - MUL_W){1'b0}}, prod_r[PROD_W-1:VAL_W]}
               * {{(VAL_W + 1 - FOLD_W){1'b0}}, fold_const}
               + {1'b0, prod_r[VAL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    two_s1_r <= use_two;
    fold_r   <= fold_nxt;
    two_s2_r <= two_s1_r;
  end

  // one conditional subtract finishes the reduction
  always_comb begin
    mod_ext = {1'b0, (two_s2_r ? MOD_TWO : MOD_ONE)};
    if (fold_r >= mod_ext) begin
      result = VAL_W'(fold_r - mod_ext);
    end else begin
      result = fold_r[VAL_W-1:0];
    end
  end

endmodule

FILE: dv/combined_lcg_shuffle_rng_top_test.sv
// Self-checking test of the combined LCG shuffle generator with random draws and reseeds.
module combined_lcg_shuffle_rng_top_test;

  localparam int VAL_W        = clsr_pkg::VAL_W;
  localparam int ENTRIES      = clsr_pkg::TABLE_ENTRIES;
  localparam int SEED_STEPS   = clsr_pkg::TABLE_ENTRIES + clsr_pkg::WARMUP_STEPS;
  localparam longint unsigned MOD_A        = 64'd2147483563;
  localparam longint unsigned MOD_B        = 64'd2147483399;
  localparam longint unsigned MUL_A        = 64'd40014;
  localparam longint unsigned MUL_B        = 64'd40692;
  localparam longint unsigned SEED_CEILING = 64'd2147383562;
  localparam int ITEM_TARGET  = 1950;
  localparam int MAX_IDLE     = 17;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // Shadow generator plus the queue of draw values still owed by the block
  class draw_scoreboard;
    longint unsigned gen_one, gen_two, prev_value;
    longint unsigned shuffle [ENTRIES];
    logic [VAL_W-1:0] expected_values [$];
    int mismatches, draws_checked, reseeds, replaced_seeds;

    function new();
      gen_one = 1;
      gen_two = 1;
      prev_value = 0;
      foreach (shuffle[i]) shuffle[i] = 0;
      mismatches = 0;
      draws_checked = 0;
      reseeds = 0;
      replaced_seeds = 0;
    endfunction

    function longint unsigned lcg_step(longint unsigned x, longint unsigned mul,
                                       longint unsigned modulus);
      return (mul * x) % modulus;
    endfunction

    // Advance the shadow state for one accepted transfer
    function void note_transfer(clsr_pkg::op_t op, logic [31:0] seed);
      longint unsigned start, bucket, idx, entry, diff;
      if (op == clsr_pkg::OP_SEED) begin
        reseeds++;
        start = seed[30:0];
        if (start == 0 || start > SEED_CEILING) begin
          start = 1;
          replaced_seeds++;
        end
        gen_one = start;
        gen_two = start;
        // run the warm-up, keeping the last values with the final one in entry 0
        for (int k = SEED_STEPS - 1; k >= 0; k--) begin
          gen_one = lcg_step(gen_one, MUL_A, MOD_A);
          if (k < ENTRIES) shuffle[k] = gen_one;
        end
        prev_value = shuffle[0];
      end else begin
        gen_one = lcg_step(gen_one, MUL_A, MOD_A);
        gen_two = lcg_step(gen_two, MUL_B, MOD_B);
        bucket = (MOD_A - 1) / ENTRIES + 1;
        idx = prev_value / bucket;
        if (idx >= ENTRIES) idx = ENTRIES - 1;
        entry = shuffle[idx];
        // wrap into 1..m1-1; equal values land on m1-1
        if (entry > gen_two) diff = entry - gen_two;
        else diff = (MOD_A - 1) - (gen_two - entry);
        shuffle[idx] = gen_one;
        prev_value = diff & 64'h7fff_ffff;
        expected_values.push_back(VAL_W'(prev_value));
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest owed value
    task check_value(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("draw result %0d with nothing owed", got));
      end else begin
        want = expected_values.pop_front();
        draws_checked++;
        if (got !== want)
          report_mismatch($sformatf("random_value got %0d want %0d", got, want));
      end
    endtask

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  clsr_pkg::op_t       in_operation     = clsr_pkg::OP_DRAW;
  logic [31:0]         in_seed_value    = '0;
  logic                out_valid;
  logic                out_ready        = 1'b0;
  logic [VAL_W-1:0]    out_random_value;

  draw_scoreboard sb;
  bit send_burst  = 1'b0;
  bit take_burst  = 1'b0;
  int items_sent  = 0;
  int cycle_count = 0;

  combined_lcg_shuffle_rng_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic drive_item(clsr_pkg::op_t op, logic [31:0] seed);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_transfer(op, seed);
    items_sent++;
  endtask

  // Hold off the sender until every owed draw has been taken
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls, then take and check each transfer
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 89 == 0) take_burst = ($urandom_range(0, 3) == 0);
      stall = take_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      sb.check_value(out_random_value);
      taken++;
    end
  end

  initial begin : stimulus
    logic [31:0] seed_word;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad seeds, the ceiling itself, dropped top bit, back-to-back seeds
    drive_item(clsr_pkg::OP_SEED, 32'h0000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'hffff_ffff);
    drive_item(clsr_pkg::OP_SEED, 32'h8000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_SEED, 32'hffff_ffff);
    drive_item(clsr_pkg::OP_DRAW, 32'h5555_5555);
    drive_item(clsr_pkg::OP_SEED, 32'd2147383562);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'haaaa_aaaa);
    drive_item(clsr_pkg::OP_SEED, 32'd2147383563);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_SEED, 32'h8000_0001);
    drive_item(clsr_pkg::OP_DRAW, 32'hffff_ffff);
    drive_item(clsr_pkg::OP_SEED, 32'h1234_5678);
    drive_item(clsr_pkg::OP_SEED, 32'h0000_0002);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    drive_item(clsr_pkg::OP_SEED, 32'h7fff_fffe);
    drive_item(clsr_pkg::OP_DRAW, 32'h0000_0000);
    hold_until_drained();

    // Random: mostly draws, an occasional reseed biased towards the edges
    while (items_sent < ITEM_TARGET) begin
      if (items_sent % 97 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (items_sent == ITEM_TARGET / 2) hold_until_drained();
      if ($urandom_range(0, 19) == 0) begin
        seed_word = $urandom;
        case ($urandom_range(0, 3))
          0: seed_word[30:0] = 31'(SEED_CEILING - 3 + $urandom_range(0, 6));
          1: seed_word[30:0] = 31'($urandom_range(0, 3));
          2: seed_word[30:0] = 31'h7fff_ffff - 31'($urandom_range(0, 3));
          default: ;
        endcase
        drive_item(clsr_pkg::OP_SEED, seed_word);
      end else begin
        drive_item(clsr_pkg::OP_DRAW, $urandom);
      end
    end

    // Drain and let any trailing reseed finish
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers in: %0d checked draws, %0d reseeds (%0d seeds replaced).",
             items_sent, sb.draws_checked, sb.reseeds, sb.replaced_seeds);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/clsr_pkg.sv
rtl/clsr_ram.sv
rtl/clsr_mulmod.sv
rtl/combined_lcg_shuffle_rng_top.sv
dv/combined_lcg_shuffle_rng_top_test.sv
